>>> rtl/drvcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// drvcc_pkg
// Shared types, constants and scaling functions for the driving control
// conditioner.
// ----------------------------------------------------------------------------

package drvcc_pkg;

    localparam int InWidth  = 40;
    localparam int OutWidth = 48;

    // steering position limits and centre
    localparam logic [7:0] SteerMin    = 8'h48;
    localparam logic [7:0] SteerMax    = 8'hB8;
    localparam logic [7:0] SteerCentre = 8'h80;

    // pedal scaling window
    localparam logic [7:0] PedalMin = 8'h30;
    localparam logic [7:0] PedalMax = 8'h90;

    localparam logic signed [7:0] SteerLimit = 8'sd127;

    // reciprocals: 2^16 / 7 and 2^22 / 97, both rounded up
    localparam logic [13:0] SteerRecip = 14'd9363;
    localparam logic [15:0] PedalRecip = 16'd43241;

    // mode codes
    localparam logic [1:0] ModeDigital      = 2'd0;
    localparam logic [1:0] ModeAnalog       = 2'd1;
    localparam logic [1:0] ModeAnalogSteer  = 2'd2;

    // register indexes
    localparam logic [1:0] RegControlMode = 2'd0;
    localparam logic [1:0] RegSteerStep   = 2'd1;
    localparam logic [1:0] RegPedalStep   = 2'd2;
    localparam logic [1:0] RegHystBypass  = 2'd3;

    // reset values
    localparam logic [7:0] SteerStepReset = 8'd3;
    localparam logic [7:0] PedalStepReset = 8'd16;

    typedef struct packed {
        logic [3:0] pad;
        logic       crash_active;
        logic [6:0] crash_frames_load;
        logic [7:0] analog_brake;
        logic [7:0] analog_accel;
        logic [7:0] analog_steer;
        logic       brake_pressed;
        logic       accel_pressed;
        logic       right_pressed;
        logic       left_pressed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] brake_level;
        logic [7:0] accel_level;
        logic [7:0] steer_position;
        logic [7:0] brake_adjust;
        logic [7:0] accel_adjust;
        logic [7:0] steer_adjust;
    } out_item_t;

    // (pos - 0x80) * 0x100 / 0x70, truncated toward zero, clamped to +-127
    // pos is always within 0x48..0xB8, so the magnitude fits six bits
    function automatic logic signed [7:0] scale_steer(input logic [7:0] pos);
        logic signed [8:0] d;
        logic [5:0]        m;
        logic [19:0]       prod;
        logic [7:0]        q;
        d    = $signed({1'b0, pos}) - $signed({1'b0, SteerCentre});
        m    = (d < 0) ? 6'(-d) : 6'(d);
        prod = 20'(m) * 20'(SteerRecip);
        q    = prod[19:12];
        if (q > 8'(SteerLimit))
        begin
            q = 8'(SteerLimit);
        end
        return (d < 0) ? -$signed(q) : $signed(q);
    endfunction

    // clamp to 0x30..0x90, then (v - 0x30) * 0x100 / 0x61
    function automatic logic [7:0] scale_pedal(input logic [7:0] v);
        logic [7:0]  c;
        logic [6:0]  x;
        logic [21:0] prod;
        c = v;
        if (c > PedalMax)
        begin
            c = PedalMax;
        end
        if (c < PedalMin)
        begin
            c = PedalMin;
        end
        x    = 7'(c - PedalMin);
        prod = 22'(x) * 22'(PedalRecip);
        return prod[21:14];
    endfunction

endpackage

`default_nettype wire

>>> rtl/driving_control_conditioner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// driving_control_conditioner
// Turns per-frame button and analog samples into steering and pedal values.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one frame tick per transfer (buttons, analog samples, crash
//   info); m_* returns exactly one result per tick (scaled steering and
//   pedals plus the raw position and levels).
//   cfg_we/cfg_index/cfg_data write one of the four control registers, picked by cfg_index;
//   write them only while no tick is in flight.
// Timing and throughput:
//   an accepted tick appears on m_tdata from the next cycle on. One tick is
//   taken every cycle while the result register is empty or being drained:
//   the state update is a single pass of clamp / ramp logic plus three small
//   constant multipliers for the scaling, all between the state registers
//   and the result register.
// Stall behavior:
//   the result register holds while m_tready is low; s_tready drops only
//   when that register is full and not being drained, so a new tick is
//   taken in the same cycle a waiting result leaves.
// Reset:
//   rst_n clears the result valid flag and puts the position at centre, the
//   pedal levels and crash counter at zero and the registers at defaults.
// ----------------------------------------------------------------------------

module driving_control_conditioner (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config write port
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [7:0]                    cfg_data,
    // frame tick input
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    // left_pressed, right_pressed, accel_pressed, brake_pressed, analog_steer,
    // analog_accel, analog_brake, crash_frames_load, crash_active, 4 zero bits
    input  wire logic [drvcc_pkg::InWidth-1:0] s_tdata,
    // result output
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    // steer_adjust, accel_adjust, brake_adjust, steer_position, accel_level,
    // brake_level
    output      logic [drvcc_pkg::OutWidth-1:0] m_tdata
);

    import drvcc_pkg::*;

    // control registers
    logic [1:0] control_mode_reg;
    logic [7:0] steer_step_reg;
    logic [7:0] pedal_step_reg;
    logic       hyst_bypass_reg;

    // conditioner state
    logic [7:0]        steer_pos_reg,  steer_pos_next;
    logic [7:0]        steer_prev_reg, steer_prev_next;
    logic signed [7:0] change_sum_reg, change_sum_next;
    logic signed [7:0] out_hold_reg,   out_hold_next;
    logic [7:0]        accel_val_reg,  accel_val_next;
    logic [7:0]        brake_val_reg,  brake_val_next;
    logic [6:0]        crash_frames_reg, crash_frames_next;

    // result register
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;

    in_item_t in_item;
    logic     accept;

    logic              analog_steer_mode;
    logic [6:0]        crash_eff;
    logic signed [9:0] ramp_pos;
    logic signed [9:0] base_pos;
    logic [7:0]        raw_pos;
    logic signed [8:0] pos_delta;
    logic signed [9:0] sum_wide;
    logic signed [7:0] scaled_steer;

    assign in_item  = in_item_t'(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // pedal ramp: step up when held, down otherwise, within 0..255
    function automatic logic [7:0] ramp_pedal(input logic [7:0] level,
                                              input logic [7:0] step,
                                              input logic       held);
        logic [8:0] up;
        logic [8:0] dn;
        up = {1'b0, level} + {1'b0, step};
        dn = {1'b0, level} - {1'b0, step};
        if (held)
        begin
            return up[8] ? 8'hFF : up[7:0];
        end
        return dn[8] ? 8'h00 : dn[7:0];
    endfunction

    always_comb
    begin
        analog_steer_mode = (control_mode_reg == ModeAnalog) ||
                            (control_mode_reg == ModeAnalogSteer);
        crash_eff = (in_item.crash_frames_load != 7'd0) ? in_item.crash_frames_load
                                                        : crash_frames_reg;

        // digital steering ramp; left wins when both buttons are held
        base_pos = $signed({2'b00, steer_pos_reg});
        ramp_pos = base_pos;
        if (in_item.left_pressed)
        begin
            if (steer_pos_reg > SteerCentre)
            begin
                base_pos = $signed({2'b00, SteerCentre});
            end
            ramp_pos = base_pos - $signed({2'b00, steer_step_reg});
            if (ramp_pos < $signed({2'b00, SteerMin}))
            begin
                ramp_pos = $signed({2'b00, SteerMin});
            end
        end
        else if (in_item.right_pressed)
        begin
            if (steer_pos_reg < SteerCentre)
            begin
                base_pos = $signed({2'b00, SteerCentre});
            end
            ramp_pos = base_pos + $signed({2'b00, steer_step_reg});
            if (ramp_pos > $signed({2'b00, SteerMax}))
            begin
                ramp_pos = $signed({2'b00, SteerMax});
            end
        end
        else if (steer_pos_reg < SteerCentre)
        begin
            // drift back to centre
            ramp_pos = base_pos + $signed({2'b00, steer_step_reg});
            if (ramp_pos > $signed({2'b00, SteerCentre}))
            begin
                ramp_pos = $signed({2'b00, SteerCentre});
            end
        end
        else if (steer_pos_reg > SteerCentre)
        begin
            ramp_pos = base_pos - $signed({2'b00, steer_step_reg});
            if (ramp_pos < $signed({2'b00, SteerCentre}))
            begin
                ramp_pos = $signed({2'b00, SteerCentre});
            end
        end

        raw_pos = analog_steer_mode ? in_item.analog_steer : ramp_pos[7:0];
        if (raw_pos < SteerMin)
        begin
            steer_pos_next = SteerMin;
        end
        else if (raw_pos > SteerMax)
        begin
            steer_pos_next = SteerMax;
        end
        else
        begin
            steer_pos_next = raw_pos;
        end

        // pedals follow the samples only in full analog mode
        if (control_mode_reg == ModeAnalog)
        begin
            accel_val_next = in_item.analog_accel;
            brake_val_next = in_item.analog_brake;
        end
        else
        begin
            accel_val_next = ramp_pedal(accel_val_reg, pedal_step_reg,
                                        in_item.accel_pressed);
            brake_val_next = ramp_pedal(brake_val_reg, pedal_step_reg,
                                        in_item.brake_pressed);
        end

        scaled_steer = in_item.crash_active ? 8'sd0 : scale_steer(steer_pos_next);

        pos_delta = $signed({1'b0, steer_pos_next}) - $signed({1'b0, steer_prev_reg});
        sum_wide  = 10'(change_sum_reg) + 10'(pos_delta);

        crash_frames_next = crash_eff;
        steer_prev_next   = steer_prev_reg;
        change_sum_next   = change_sum_reg;
        out_hold_next     = out_hold_reg;
        if (crash_eff != 7'd0)
        begin
            // crash recovery: steer directly, leave hysteresis alone
            crash_frames_next = crash_eff - 7'd1;
            out_hold_next     = scaled_steer;
        end
        else
        begin
            // small accumulated changes are held off unless bypass is set
            steer_prev_next = steer_pos_next;
            change_sum_next = sum_wide[7:0];
            if (hyst_bypass_reg || (sum_wide > 10'sd2) || (sum_wide < -10'sd2))
            begin
                change_sum_next = 8'sd0;
                out_hold_next   = scaled_steer;
            end
        end

        out_data_next.steer_adjust   = out_hold_next;
        out_data_next.accel_adjust   = scale_pedal(accel_val_next);
        out_data_next.brake_adjust   = scale_pedal(brake_val_next);
        out_data_next.steer_position = steer_pos_next;
        out_data_next.accel_level    = accel_val_next;
        out_data_next.brake_level    = brake_val_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_mode_reg <= ModeDigital;
            steer_step_reg   <= SteerStepReset;
            pedal_step_reg   <= PedalStepReset;
            hyst_bypass_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegControlMode: control_mode_reg <= cfg_data[1:0];
                RegSteerStep:   steer_step_reg   <= cfg_data;
                RegPedalStep:   pedal_step_reg   <= cfg_data;
                RegHystBypass:  hyst_bypass_reg  <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // conditioner state, updated once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_pos_reg    <= SteerCentre;
            steer_prev_reg   <= SteerCentre;
            change_sum_reg   <= 8'sd0;
            out_hold_reg     <= 8'sd0;
            accel_val_reg    <= 8'd0;
            brake_val_reg    <= 8'd0;
            crash_frames_reg <= 7'd0;
        end
        else if (accept)
        begin
            steer_pos_reg    <= steer_pos_next;
            steer_prev_reg   <= steer_prev_next;
            change_sum_reg   <= change_sum_next;
            out_hold_reg     <= out_hold_next;
            accel_val_reg    <= accel_val_next;
            brake_val_reg    <= brake_val_next;
            crash_frames_reg <= crash_frames_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    // stored position never leaves the steering window
    assert property (@(posedge clk) disable iff (!rst_n)
        (steer_pos_reg >= SteerMin) && (steer_pos_reg <= SteerMax))
        else $error("steering position out of range");

    // crash counter counts down by one when not reloaded
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_item.crash_frames_load == 7'd0) && (crash_frames_reg != 7'd0)
        |=> crash_frames_reg == $past(crash_frames_reg) - 7'd1)
        else $error("crash counter did not decrement");

    // with hysteresis bypass set and no crash pending the change sum is cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && hyst_bypass_reg && (crash_eff == 7'd0)
        |=> change_sum_reg == 8'sd0)
        else $error("change sum not cleared");

    // hysteresis sum stays small between ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        (change_sum_reg <= 8'sd2) && (change_sum_reg >= -8'sd2))
        else $error("change sum exceeded hysteresis band");

    // scaled outputs stay in their ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.steer_adjust != 8'h80) &&
                          (out_data_reg.accel_adjust <= 8'd253) &&
                          (out_data_reg.brake_adjust <= 8'd253))
        else $error("scaled output out of range");
`endif

endmodule

`default_nettype wire
